// ===== rtl/brace_template_tokenizer_core_macros.svh =====
`ifndef BRACE_TEMPLATE_TOKENIZER_CORE_MACROS_SVH
`define BRACE_TEMPLATE_TOKENIZER_CORE_MACROS_SVH

// implication checked in the same cycle, sampled on clk, off during reset
`define BTT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tokenizer check failed");

// implication checked in the next cycle
`define BTT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tokenizer check failed");

`endif

// ===== rtl/btt_pkg.sv =====
package btt_pkg;

  typedef enum logic [2:0] {
    PH_TEXT   = 3'd0,
    PH_OPEN   = 3'd1,
    PH_CLOSE  = 3'd2,
    PH_PREWS  = 3'd3,
    PH_NAME   = 3'd4,
    PH_POSTWS = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    EV_CHAR = 2'd0,
    EV_END  = 2'd1,
    EV_ERR  = 2'd2,
    EV_DONE = 2'd3
  } event_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_EOF       = 3'd1,
    ERR_BADSTART  = 3'd2,
    ERR_NOCLOSE   = 3'd3,
    ERR_UNMATCHED = 3'd4
  } err_t;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic TYPE_LIT = 1'b0;
  localparam logic TYPE_VAR = 1'b1;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // result queue: room for two results per item plus the ones in flight
  localparam int RES_DEPTH = 4;
  localparam int PTR_W     = $clog2(RES_DEPTH);
  localparam int CNT_W     = $clog2(RES_DEPTH + 1);

  typedef struct packed {
    logic       kind;
    logic [7:0] char_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0] event_res;
    logic       comp_type;
    logic [7:0] char_out;
    logic [2:0] error_code;
    logic       last;
  } out_item_t;

  typedef struct packed {
    phase_t phase;
    logic   literal_open;
    logic   error_seen;
  } btt_state_t;

  localparam btt_state_t STATE_RESET = '{phase: PH_TEXT, literal_open: 1'b0,
                                        error_seen: 1'b0};

endpackage

// ===== rtl/brace_template_tokenizer_core.sv =====
// Brace template tokenizer. One template byte or an end mark is taken per transfer
// and split into literal and variable-name components, each character tagged with its
// component type and each component closed by an end event; errors and a done event
// are reported in-line. An item is registered on entry, decoded combinationally by the
// step logic and its one or two results are pushed into a four-entry result queue.
// Sustained rate is one item per cycle while items give at most one result each and
// the sink keeps up; items giving two results (doubled braces, close or EOF error
// before done) leave one at a time through the single result port. The first result
// passes the input register and the result queue before it appears. Input is held
// off only when the queue could not take two more results.
`include "brace_template_tokenizer_core_macros.svh"

module brace_template_tokenizer_core
  import btt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic             in_valid_r;
  in_item_t         in_data_r;
  btt_state_t       st_r, st_nxt;
  logic [1:0]       res_n;
  out_item_t        res0, res1;
  logic [CNT_W-1:0] fill;
  logic             advance;
  logic             pop;

  // the queue must hold two more results before an item is decoded
  assign advance  = in_valid_r && (fill <= CNT_W'(RES_DEPTH - 2));
  assign in_ready = !in_valid_r || advance;
  assign pop      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      st_r       <= STATE_RESET;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_data_r <= in_data;
    end
  end

  btt_step u_step (
    .st     (st_r),
    .item   (in_data_r),
    .res_n  (res_n),
    .res0   (res0),
    .res1   (res1),
    .st_nxt (st_nxt)
  );

  btt_result_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_n  (advance ? res_n : 2'd0),
    .push_d0 (res0),
    .push_d1 (res1),
    .pop     (pop),
    .fill    (fill),
    .head    (out_data)
  );

  assign out_valid = (fill != '0);

  `BTT_ASSERT_NOW(a_fill_bound, 1'b1, fill <= CNT_W'(RES_DEPTH))
  `BTT_ASSERT_NOW(a_done_is_last, out_valid && out_data.event_res == EV_DONE, out_data.last)
  `BTT_ASSERT_NOW(a_err_code, out_valid, (out_data.event_res == EV_ERR) == (out_data.error_code != ERR_NONE))
  `BTT_ASSERT_NEXT(a_end_resets, advance && in_data_r.kind == KIND_END, st_r == STATE_RESET)

endmodule

// ===== rtl/btt_step.sv =====
module btt_step
  import btt_pkg::*;
(
  input  btt_state_t st,
  input  in_item_t   item,
  output logic [1:0] res_n,
  output out_item_t  res0,
  output out_item_t  res1,
  output btt_state_t st_nxt
);

  function automatic logic is_ws(input logic [7:0] c);
    return (c >= 8'd9 && c <= 8'd13) || c == 8'd32;
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic out_item_t mk(input event_t ev, input logic ty,
                                   input logic [7:0] ch, input err_t err);
    out_item_t r;
    r.event_res  = ev;
    r.comp_type  = ty;
    r.char_out   = ch;
    r.error_code = err;
    r.last       = 1'b0;
    return r;
  endfunction

  logic [7:0] c;
  logic       in_brace;
  out_item_t  r0, r1;
  logic [1:0] n;

  assign c = item.char_in;
  // unused phase codes count as text
  assign in_brace = (st.phase == PH_OPEN) || (st.phase == PH_CLOSE) ||
                    (st.phase == PH_PREWS) || (st.phase == PH_NAME) ||
                    (st.phase == PH_POSTWS);

  always_comb begin
    r0     = '0;
    r1     = '0;
    n      = 2'd0;
    st_nxt = st;
    if (item.kind == KIND_END) begin
      st_nxt = STATE_RESET;
      if (!st.error_seen && in_brace) begin
        r0 = mk(EV_ERR, TYPE_LIT, 8'd0, ERR_EOF);
        r1 = mk(EV_DONE, TYPE_LIT, 8'd0, ERR_NONE);
        n  = 2'd2;
      end else if (!st.error_seen && st.literal_open) begin
        r0 = mk(EV_END, TYPE_LIT, 8'd0, ERR_NONE);
        r1 = mk(EV_DONE, TYPE_LIT, 8'd0, ERR_NONE);
        n  = 2'd2;
      end else begin
        r0 = mk(EV_DONE, TYPE_LIT, 8'd0, ERR_NONE);
        n  = 2'd1;
      end
    end else if (!st.error_seen) begin
      unique case (st.phase)
        PH_OPEN: begin
          if (c == CH_LBRACE) begin
            r0 = mk(EV_CHAR, TYPE_LIT, c, ERR_NONE);
            r1 = mk(EV_END, TYPE_LIT, 8'd0, ERR_NONE);
            n  = 2'd2;
            st_nxt.phase = PH_TEXT;
          end else if (is_ws(c)) begin
            st_nxt.phase = PH_PREWS;
          end else if (is_alnum(c)) begin
            r0 = mk(EV_CHAR, TYPE_VAR, c, ERR_NONE);
            n  = 2'd1;
            st_nxt.phase = PH_NAME;
          end else begin
            r0 = mk(EV_ERR, TYPE_LIT, 8'd0, ERR_BADSTART);
            n  = 2'd1;
            st_nxt.error_seen = 1'b1;
          end
        end
        PH_CLOSE: begin
          if (c == CH_RBRACE) begin
            r0 = mk(EV_CHAR, TYPE_LIT, c, ERR_NONE);
            r1 = mk(EV_END, TYPE_LIT, 8'd0, ERR_NONE);
            n  = 2'd2;
            st_nxt.phase = PH_TEXT;
          end else begin
            r0 = mk(EV_ERR, TYPE_LIT, 8'd0, ERR_UNMATCHED);
            n  = 2'd1;
            st_nxt.error_seen = 1'b1;
          end
        end
        PH_PREWS: begin
          if (is_ws(c)) begin
            st_nxt.phase = PH_PREWS;
          end else if (is_alnum(c)) begin
            r0 = mk(EV_CHAR, TYPE_VAR, c, ERR_NONE);
            n  = 2'd1;
            st_nxt.phase = PH_NAME;
          end else begin
            r0 = mk(EV_ERR, TYPE_LIT, 8'd0, ERR_BADSTART);
            n  = 2'd1;
            st_nxt.error_seen = 1'b1;
          end
        end
        PH_NAME: begin
          if (is_alnum(c)) begin
            r0 = mk(EV_CHAR, TYPE_VAR, c, ERR_NONE);
            n  = 2'd1;
          end else if (is_ws(c)) begin
            st_nxt.phase = PH_POSTWS;
          end else if (c == CH_RBRACE) begin
            r0 = mk(EV_END, TYPE_VAR, 8'd0, ERR_NONE);
            n  = 2'd1;
            st_nxt.phase = PH_TEXT;
          end else begin
            r0 = mk(EV_ERR, TYPE_LIT, 8'd0, ERR_NOCLOSE);
            n  = 2'd1;
            st_nxt.error_seen = 1'b1;
          end
        end
        PH_POSTWS: begin
          if (is_ws(c)) begin
            st_nxt.phase = PH_POSTWS;
          end else if (c == CH_RBRACE) begin
            r0 = mk(EV_END, TYPE_VAR, 8'd0, ERR_NONE);
            n  = 2'd1;
            st_nxt.phase = PH_TEXT;
          end else begin
            r0 = mk(EV_ERR, TYPE_LIT, 8'd0, ERR_NOCLOSE);
            n  = 2'd1;
            st_nxt.error_seen = 1'b1;
          end
        end
        default: begin
          if (c == CH_LBRACE || c == CH_RBRACE) begin
            // a brace closes any open text run
            if (st.literal_open) begin
              r0 = mk(EV_END, TYPE_LIT, 8'd0, ERR_NONE);
              n  = 2'd1;
            end
            st_nxt.literal_open = 1'b0;
            st_nxt.phase = (c == CH_LBRACE) ? PH_OPEN : PH_CLOSE;
          end else begin
            r0 = mk(EV_CHAR, TYPE_LIT, c, ERR_NONE);
            n  = 2'd1;
            st_nxt.literal_open = 1'b1;
            st_nxt.phase = PH_TEXT;
          end
        end
      endcase
    end
  end

  always_comb begin
    res0 = r0;
    res1 = r1;
    res0.last = (n == 2'd1);
    res1.last = (n == 2'd2);
  end

  assign res_n = n;

endmodule

// ===== rtl/btt_result_fifo.sv =====
module btt_result_fifo
  import btt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       push_n,
  input  out_item_t        push_d0,
  input  out_item_t        push_d1,
  input  logic             pop,
  output logic [CNT_W-1:0] fill,
  output out_item_t        head
);

  out_item_t        entries_r [RES_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [PTR_W-1:0] wr_ptr_nxt, rd_ptr_nxt, wr_ptr_p1;
  logic [CNT_W-1:0] count_nxt;

  assign wr_ptr_p1  = wr_ptr_r + PTR_W'(1);
  assign wr_ptr_nxt = wr_ptr_r + PTR_W'(push_n);
  assign rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
  assign count_nxt  = count_r + CNT_W'(push_n) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      entries_r[wr_ptr_r] <= push_d0;
    end
    if (push_n == 2'd2) begin
      entries_r[wr_ptr_p1] <= push_d1;
    end
  end

  assign fill = count_r;
  assign head = entries_r[rd_ptr_r];

endmodule
